[design/ssp_pkg.sv]
// Package for the soft-sphere periodic force block: widths, codes, image table.
// No dependencies; used by ssp_pair, the top level and the bench.
package ssp_pkg;

  localparam int unsigned MaxParticlesDef = 4096;
  localparam int unsigned CoordW = 24;
  localparam int unsigned RadW   = 20;
  localparam int unsigned BoxW   = 23;
  localparam int unsigned GainW  = 16;
  localparam int unsigned CountW = 13;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned ForceW = 32;
  localparam int unsigned EntryW = 3 * CoordW + RadW;
  localparam int unsigned ImgN   = 27;

  localparam logic [GainW-1:0]  GainReset  = 16'd6554;
  localparam logic [CountW-1:0] CountReset = 13'd1;

  typedef enum logic [2:0] {
    REG_BOX_X = 3'd0,
    REG_BOX_Y = 3'd1,
    REG_BOX_Z = 3'd2,
    REG_GAIN  = 3'd3,
    REG_COUNT = 3'd4
  } reg_idx_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Per-axis offset codes: 00 none, 01 plus box, 10 minus box.
  typedef logic [1:0] ofs_t;
  localparam ofs_t OFS_NONE  = 2'b00;
  localparam ofs_t OFS_PLUS  = 2'b01;
  localparam ofs_t OFS_MINUS = 2'b10;

  typedef struct packed {
    ofs_t x;
    ofs_t y;
    ofs_t z;
  } img_t;

  function automatic img_t image_of(input logic [4:0] im);
    img_t r;
    ofs_t a;
    ofs_t b;
    logic [4:0] k;
    r = '0;
    a = OFS_NONE;
    b = OFS_NONE;
    k = 5'd0;
    if (im == 5'd0) begin
      r = '{OFS_NONE, OFS_NONE, OFS_NONE};
    end else begin
      if (im <= 5'd8) begin
        r.z = OFS_NONE;
        k = im - 5'd1;
      end else if (im <= 5'd17) begin
        r.z = OFS_PLUS;
        k = im - 5'd9;
      end else begin
        r.z = OFS_MINUS;
        k = im - 5'd18;
      end
      // Within a z plane: the 8 xy pairs, or (0,0) first in the z planes.
      if (im > 5'd8) begin
        if (k == 5'd0) begin
          a = OFS_NONE; b = OFS_NONE;
        end else begin
          k = k - 5'd1;
          case (k)
            5'd0:    begin a = OFS_MINUS; b = OFS_NONE;  end
            5'd1:    begin a = OFS_PLUS;  b = OFS_NONE;  end
            5'd2:    begin a = OFS_NONE;  b = OFS_PLUS;  end
            5'd3:    begin a = OFS_NONE;  b = OFS_MINUS; end
            5'd4:    begin a = OFS_PLUS;  b = OFS_PLUS;  end
            5'd5:    begin a = OFS_PLUS;  b = OFS_MINUS; end
            5'd6:    begin a = OFS_MINUS; b = OFS_PLUS;  end
            default: begin a = OFS_MINUS; b = OFS_MINUS; end
          endcase
        end
      end else begin
        case (k)
          5'd0:    begin a = OFS_MINUS; b = OFS_NONE;  end
          5'd1:    begin a = OFS_PLUS;  b = OFS_NONE;  end
          5'd2:    begin a = OFS_NONE;  b = OFS_PLUS;  end
          5'd3:    begin a = OFS_NONE;  b = OFS_MINUS; end
          5'd4:    begin a = OFS_PLUS;  b = OFS_PLUS;  end
          5'd5:    begin a = OFS_PLUS;  b = OFS_MINUS; end
          5'd6:    begin a = OFS_MINUS; b = OFS_PLUS;  end
          default: begin a = OFS_MINUS; b = OFS_MINUS; end
        endcase
      end
      r.x = a;
      r.y = b;
    end
    return r;
  endfunction

endpackage

[design/ssp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ssp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/ssp_pair.sv]
// Pair pipeline: image offset, distance test, force term, saturating accumulate.
// Depends on ssp_pkg.
module ssp_pair (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clr,
  input  logic                                vld,
  input  logic signed [ssp_pkg::CoordW-1:0]   xi,
  input  logic signed [ssp_pkg::CoordW-1:0]   yi,
  input  logic signed [ssp_pkg::CoordW-1:0]   zi,
  input  logic [ssp_pkg::RadW-1:0]            ri,
  input  logic [ssp_pkg::EntryW-1:0]          ent,
  input  ssp_pkg::img_t                       img,
  input  logic [ssp_pkg::BoxW-1:0]            box_x,
  input  logic [ssp_pkg::BoxW-1:0]            box_y,
  input  logic [ssp_pkg::BoxW-1:0]            box_z,
  input  logic [ssp_pkg::GainW-1:0]           gain,
  output logic                                busy,
  output logic signed [ssp_pkg::ForceW-1:0]   fx,
  output logic signed [ssp_pkg::ForceW-1:0]   fy,
  output logic signed [ssp_pkg::ForceW-1:0]   fz,
  output logic                                sat
);

  localparam int unsigned DW = 27;  // coordinate difference plus box offset
  localparam int unsigned SW = 2 * DW + 2;

  // Stage 1: differences.
  localparam int unsigned RadW_L = ssp_pkg::RadW + 1;
  logic s1_r;
  logic signed [DW-1:0] dx1_r, dy1_r, dz1_r;
  logic [RadW_L-1:0] rs1_r;

  function automatic logic signed [DW-1:0] diff(input logic signed [23:0] cj,
      input logic signed [23:0] ci, input ssp_pkg::ofs_t o, input logic [22:0] bx);
    logic signed [DW-1:0] off;
    off = '0;
    case (o)
      ssp_pkg::OFS_PLUS:  off = DW'($signed({1'b0, bx}));
      ssp_pkg::OFS_MINUS: off = -DW'($signed({1'b0, bx}));
      default:            off = '0;
    endcase
    return DW'(cj) - DW'(ci) + off;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0;
    end else begin
      s1_r <= vld;
    end
    dx1_r <= diff(ent[23:0], xi, img.x, box_x);
    dy1_r <= diff(ent[47:24], yi, img.y, box_y);
    dz1_r <= diff(ent[71:48], zi, img.z, box_z);
    rs1_r <= RadW_L'(ri) + RadW_L'(ent[91:72]);
  end

  // Stage 2: squares (each at most 27x27) and the squared radius sum.
  logic s2_r;
  logic [SW-3:0] qx2_r, qy2_r, qz2_r;
  logic [2*RadW_L-1:0] rr2_r;
  logic signed [DW-1:0] dx2_r, dy2_r, dz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= 1'b0;
    end else begin
      s2_r <= s1_r;
    end
    qx2_r <= (SW-2)'(dx1_r * dx1_r);
    qy2_r <= (SW-2)'(dy1_r * dy1_r);
    qz2_r <= (SW-2)'(dz1_r * dz1_r);
    rr2_r <= rs1_r * rs1_r;
    dx2_r <= dx1_r;
    dy2_r <= dy1_r;
    dz2_r <= dz1_r;
  end

  // Stage 3: compare and terms.
  localparam int unsigned ForceW_L = 34;
  logic s3_r, hit3_r;
  logic signed [ForceW_L-1:0] tx3_r, ty3_r, tz3_r;

  function automatic logic signed [ForceW_L-1:0] term(input logic signed [DW-1:0] d,
      input logic [15:0] g);
    logic [DW-1:0] mag;
    logic [DW+16:0] m;
    logic [ForceW_L-1:0] r;
    mag = d[DW-1] ? DW'(-d) : DW'(d);
    m = (DW+17)'(mag) * (DW+17)'(g) + (DW+17)'(32768);
    r = ForceW_L'(m >> 16);
    return d[DW-1] ? $signed(r) : -$signed(r);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r <= 1'b0;
    end else begin
      s3_r <= s2_r;
    end
    hit3_r <= (SW'(qx2_r) + SW'(qy2_r) + SW'(qz2_r)) < SW'(rr2_r);
    tx3_r <= term(dx2_r, gain);
    ty3_r <= term(dy2_r, gain);
    tz3_r <= term(dz2_r, gain);
  end

  // Stage 4: saturating accumulators.
  function automatic logic signed [ForceW_L-1:0] sadd(input logic signed [31:0] a,
      input logic signed [ForceW_L-1:0] t);
    logic signed [ForceW_L-1:0] v;
    v = ForceW_L'(a) + t;
    if (v > ForceW_L'(32'sh7fffffff)) v = ForceW_L'(32'sh7fffffff);
    if (v < -ForceW_L'(64'sh80000000)) v = -ForceW_L'(64'sh80000000);
    return v;
  endfunction

  logic signed [ForceW_L-1:0] nx, ny, nz;
  logic ovx, ovy, ovz;

  always_comb begin
    nx = sadd(fx, tx3_r);
    ny = sadd(fy, ty3_r);
    nz = sadd(fz, tz3_r);
    ovx = (ForceW_L'(fx) + tx3_r) != nx;
    ovy = (ForceW_L'(fy) + ty3_r) != ny;
    ovz = (ForceW_L'(fz) + tz3_r) != nz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      fx <= '0;
      fy <= '0;
      fz <= '0;
      sat <= 1'b0;
    end else if (s3_r && hit3_r) begin
      fx <= nx[31:0];
      fy <= ny[31:0];
      fz <= nz[31:0];
      sat <= sat | ovx | ovy | ovz;
    end
  end

  assign busy = s1_r | s2_r | s3_r;

endmodule

[design/soft_sphere_periodic_force.sv]
// Top level of the soft-sphere periodic force block.
// Depends on ssp_pkg, ssp_ram and ssp_pair.
//
// Usage: beats on in_* either load a particle entry (action 0) or query the
// summed overlap force on one entry (action 1). A load yields no result. A
// query yields one out_* beat carrying force_x/y/z and the saturated flag.
// Registers are to be written on cfg_* only while idle; the block does not
// enforce this. A query steps through fetching the queried entry, evaluating
// the image gates, the scan and the pair pipeline drain, then shows its result.
// The scan walks all 27 periodic images in a fixed order; an enabled image
// visits each table entry below particle_count, a disabled image visits none.
// The particle table is a single read port memory that every pair visit goes
// through, which sets the pace of one entry per cycle. One item is processed
// at a time. Reset clears control state and restores register defaults;
// table contents are undefined until loaded. When out_tready is low the result
// stays in the output register; in_tready remains low until it has been taken.
module soft_sphere_periodic_force #(
  parameter int unsigned MAX_PARTICLES = ssp_pkg::MaxParticlesDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [0] action
  input  logic [0:0]   in_tuser,
  // [11:0] index, [35:12] pos_x, [59:36] pos_y, [83:60] pos_z, [103:84] radius
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] force_x, [63:32] force_y, [95:64] force_z, [96] saturated
  output logic [103:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [22:0]  cfg_data
);

  localparam int unsigned AW = $clog2(MAX_PARTICLES);
  localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FETCH = 6'b000010,
    ST_GATE  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [ssp_pkg::BoxW-1:0]   box_x_r, box_y_r, box_z_r;
  logic [ssp_pkg::GainW-1:0]  gain_r;
  logic [ssp_pkg::CountW-1:0] count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r <= '0;
      box_y_r <= '0;
      box_z_r <= '0;
      gain_r  <= ssp_pkg::GainReset;
      count_r <= ssp_pkg::CountReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssp_pkg::REG_BOX_X: box_x_r <= cfg_data;
        ssp_pkg::REG_BOX_Y: box_y_r <= cfg_data;
        ssp_pkg::REG_BOX_Z: box_z_r <= cfg_data;
        ssp_pkg::REG_GAIN:  gain_r  <= cfg_data[15:0];
        ssp_pkg::REG_COUNT: count_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;

  logic [11:0] in_idx;
  assign in_idx = in_tdata[11:0];
  logic [AW-1:0] in_addr;
  assign in_addr = AW'(in_idx);
  logic idx_ok;
  assign idx_ok = 32'(in_idx) < MAX_PARTICLES;

  // Particle table: one memory, entry = {radius, z, y, x}.
  logic                       we;
  logic [AW-1:0]              raddr;
  logic [ssp_pkg::EntryW-1:0] rdata;
  logic [AW-1:0]              j_r, j_nxt;
  logic [AW-1:0]              qidx_r;

  assign we = in_acc && (in_tuser[0] == ssp_pkg::ACT_LOAD) && idx_ok;

  ssp_ram #(.WIDTH(ssp_pkg::EntryW), .DEPTH(MAX_PARTICLES)) u_tab (
    .clk   (clk),
    .we    (we),
    .waddr (in_addr),
    .wdata (in_tdata[103:12]),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign raddr = (state_r == ST_IDLE) ? in_addr : j_r;

  // Queried particle and image gates.
  logic signed [23:0] xi_r, yi_r, zi_r;
  logic [19:0]        ri_r;
  logic [5:0]         gate_r;  // {mz,pz,my,py,mx,px}
  logic               qvalid_r;

  function automatic logic gp(input logic signed [23:0] c, input logic [19:0] r,
      input logic [22:0] b);
    logic signed [29:0] l, rt;
    l  = 30'(c) * 30'sd10;
    rt = 30'($signed({1'b0, b})) * 30'sd10 - 30'($signed({1'b0, r})) * 30'sd11;
    return l > rt;
  endfunction

  function automatic logic gm(input logic signed [23:0] c, input logic [19:0] r);
    return (30'(c) * 30'sd10) < (30'($signed({1'b0, r})) * 30'sd11);
  endfunction

  logic [4:0] im_r, im_nxt;
  ssp_pkg::img_t img_cur;
  assign img_cur = ssp_pkg::image_of(im_r);

  function automatic logic axis_ok(input ssp_pkg::ofs_t o, input logic p, input logic m);
    case (o)
      ssp_pkg::OFS_PLUS:  return p;
      ssp_pkg::OFS_MINUS: return m;
      default:            return 1'b1;
    endcase
  endfunction

  logic img_en;
  assign img_en = axis_ok(img_cur.x, gate_r[0], gate_r[1]) &&
                  axis_ok(img_cur.y, gate_r[2], gate_r[3]) &&
                  axis_ok(img_cur.z, gate_r[4], gate_r[5]);

  logic [CW-1:0] n_eff;
  assign n_eff = (32'(count_r) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(count_r);

  // Pair visit: address j in SCAN, data valid in the next cycle.
  logic          issue;
  logic          pv_r;
  ssp_pkg::img_t pimg_r;
  logic          busy;
  logic [4:0]    drain_r;
  logic          last_j;

  assign last_j = (CW'(j_r) + CW'(1)) >= n_eff;
  assign issue  = (state_r == ST_SCAN) && img_en && (n_eff != '0);

  always_comb begin
    state_nxt = state_r;
    j_nxt = j_r;
    im_nxt = im_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser[0] == ssp_pkg::ACT_QUERY) begin
          state_nxt = idx_ok ? ST_FETCH : ST_DRAIN;
        end
      end
      ST_FETCH: state_nxt = ST_GATE;
      ST_GATE: begin
        state_nxt = ST_SCAN;
        im_nxt = '0;
        j_nxt = '0;
      end
      ST_SCAN: begin
        if (issue && !last_j) begin
          j_nxt = j_r + AW'(1);
        end else begin
          j_nxt = '0;
          if (im_r == 5'(ssp_pkg::ImgN - 1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            im_nxt = im_r + 5'd1;
          end
        end
      end
      ST_DRAIN: begin
        if (drain_r == 5'd0) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      j_r      <= '0;
      im_r     <= '0;
      pv_r     <= 1'b0;
      qvalid_r <= 1'b0;
      drain_r  <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      im_r    <= im_nxt;
      pv_r    <= issue;
      if (state_r == ST_IDLE && in_acc) qvalid_r <= idx_ok;
      if (state_nxt == ST_DRAIN && state_r != ST_DRAIN) drain_r <= 5'd5;
      else if (drain_r != '0) drain_r <= drain_r - 5'd1;
    end
    pimg_r <= img_cur;
    if (state_r == ST_IDLE) qidx_r <= in_addr;
    if (state_r == ST_FETCH) begin
      xi_r <= rdata[23:0];
      yi_r <= rdata[47:24];
      zi_r <= rdata[71:48];
      ri_r <= rdata[91:72];
    end
    if (state_r == ST_GATE) begin
      gate_r <= {gm(zi_r, ri_r), gp(zi_r, ri_r, box_z_r),
                 gm(yi_r, ri_r), gp(yi_r, ri_r, box_y_r),
                 gm(xi_r, ri_r), gp(xi_r, ri_r, box_x_r)};
    end
  end

  logic signed [31:0] fx, fy, fz;
  logic               sat;

  ssp_pair u_pair (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (in_acc),
    .vld   (pv_r),
    .xi    (xi_r),
    .yi    (yi_r),
    .zi    (zi_r),
    .ri    (ri_r),
    .ent   (rdata),
    .img   (pimg_r),
    .box_x (box_x_r),
    .box_y (box_y_r),
    .box_z (box_z_r),
    .gain  (gain_r),
    .busy  (busy),
    .fx    (fx),
    .fy    (fy),
    .fz    (fz),
    .sat   (sat)
  );

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = qvalid_r ? {7'd0, sat, fz, fy, fx} : '0;

`ifndef SYNTH
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !busy)
    else $error("result shown while pair pipeline busy");
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready)
    else $error("input accepted during scan");
  a_qidx_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> $stable(qidx_r))
    else $error("query index changed mid scan");
  a_drain_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && drain_r == 5'd0) |=> out_tvalid)
    else $error("drain did not lead to result");
`endif

endmodule

[bench/ssp_checker.sv]
`timescale 1ns / 100ps
// Checker for soft_sphere_periodic_force: watches the in, out and cfg channels,
// predicts each query result from its own copy of the particle table and registers.
// Depends on ssp_pkg for the register and action codes.
module ssp_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [0:0]   in_tuser,
  input  logic [103:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [22:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  localparam int TableDepth = 4096;

  typedef struct {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic        sat;
  } force_t;

  // Image offsets per axis, in the order the sums are accumulated.
  localparam int ImgSx [27] = '{0, -1, 1, 0, 0, 1, 1, -1, -1,
                                0, -1, 1, 0, 0, 1, 1, -1, -1,
                                0, -1, 1, 0, 0, 1, 1, -1, -1};
  localparam int ImgSy [27] = '{0, 0, 0, 1, -1, 1, -1, 1, -1,
                                0, 0, 0, 1, -1, 1, -1, 1, -1,
                                0, 0, 0, 1, -1, 1, -1, 1, -1};
  localparam int ImgSz [27] = '{0, 0, 0, 0, 0, 0, 0, 0, 0,
                                1, 1, 1, 1, 1, 1, 1, 1, 1,
                                -1, -1, -1, -1, -1, -1, -1, -1, -1};

  longint pos_x [TableDepth];
  longint pos_y [TableDepth];
  longint pos_z [TableDepth];
  longint rad   [TableDepth];
  longint box_x, box_y, box_z, gain, count;
  force_t force_due [$];
  int     mismatches;

  function automatic logic axis_open(int s, logic plus, logic minus);
    if (s > 0) return plus;
    if (s < 0) return minus;
    return 1'b1;
  endfunction

  // Repulsive term for one axis, rounded half away from zero.
  function automatic longint overlap_term(longint d);
    longint mag;
    longint r;
    mag = (d < 0) ? -d : d;
    r = (mag * gain + 32768) >>> 16;
    return (d < 0) ? r : -r;
  endfunction

  function automatic void clamp_add(inout longint acc, input longint t, inout logic sat);
    longint v;
    v = acc + t;
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      sat = 1'b1;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      sat = 1'b1;
    end
    acc = v;
  endfunction

  function automatic force_t sum_overlap_force(int i);
    force_t res;
    longint xi, yi, zi, ri, fx, fy, fz, dx, dy, dz, rs, n;
    logic px, mx, py, my, pz, mz, sat;
    xi = pos_x[i]; yi = pos_y[i]; zi = pos_z[i]; ri = rad[i];
    px = (10 * xi) > (10 * box_x - 11 * ri);
    py = (10 * yi) > (10 * box_y - 11 * ri);
    pz = (10 * zi) > (10 * box_z - 11 * ri);
    mx = (10 * xi) < (11 * ri);
    my = (10 * yi) < (11 * ri);
    mz = (10 * zi) < (11 * ri);
    fx = 0; fy = 0; fz = 0; sat = 1'b0;
    n = (count > TableDepth) ? longint'(TableDepth) : count;
    for (int im = 0; im < 27; im++) begin
      if (axis_open(ImgSx[im], px, mx) && axis_open(ImgSy[im], py, my) &&
          axis_open(ImgSz[im], pz, mz)) begin
        for (int j = 0; j < n; j++) begin
          dx = pos_x[j] + ImgSx[im] * box_x - xi;
          dy = pos_y[j] + ImgSy[im] * box_y - yi;
          dz = pos_z[j] + ImgSz[im] * box_z - zi;
          rs = ri + rad[j];
          if (dx * dx + dy * dy + dz * dz < rs * rs) begin
            clamp_add(fx, overlap_term(dx), sat);
            clamp_add(fy, overlap_term(dy), sat);
            clamp_add(fz, overlap_term(dz), sat);
          end
        end
      end
    end
    res.fx = fx[31:0];
    res.fy = fy[31:0];
    res.fz = fz[31:0];
    res.sat = sat;
    return res;
  endfunction

  initial begin
    fail_count = 0;
    mismatches = 0;
    pending = 0;
    for (int k = 0; k < TableDepth; k++) begin
      pos_x[k] = 0; pos_y[k] = 0; pos_z[k] = 0; rad[k] = 0;
    end
  end

  // Handshake signals are sampled mid-cycle; a beat seen here is taken at the next edge.
  always @(negedge clk) begin
    force_t exp_f;
    int     idx;
    if (!rst_n) begin
      box_x = 0; box_y = 0; box_z = 0;
      gain = longint'(ssp_pkg::GainReset);
      count = longint'(ssp_pkg::CountReset);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (ssp_pkg::reg_idx_t'(cfg_index))
          ssp_pkg::REG_BOX_X: box_x = longint'(cfg_data);
          ssp_pkg::REG_BOX_Y: box_y = longint'(cfg_data);
          ssp_pkg::REG_BOX_Z: box_z = longint'(cfg_data);
          ssp_pkg::REG_GAIN:  gain  = longint'(cfg_data[15:0]);
          ssp_pkg::REG_COUNT: count = longint'(cfg_data[12:0]);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        idx = int'(in_tdata[11:0]);
        if (in_tuser[0] == ssp_pkg::ACT_LOAD) begin
          pos_x[idx] = longint'($signed(in_tdata[35:12]));
          pos_y[idx] = longint'($signed(in_tdata[59:36]));
          pos_z[idx] = longint'($signed(in_tdata[83:60]));
          rad[idx]   = longint'(in_tdata[103:84]);
        end else begin
          force_due.push_back(sum_overlap_force(idx));
        end
      end
      if (out_tvalid && out_tready) begin
        if (force_due.size() == 0) begin
          fail_count++;
          if (mismatches < 10)
            $display("ERROR: result beat with no query outstanding: %h", out_tdata);
          mismatches++;
        end else begin
          exp_f = force_due.pop_front();
          if (out_tdata[31:0] !== exp_f.fx || out_tdata[63:32] !== exp_f.fy ||
              out_tdata[95:64] !== exp_f.fz || out_tdata[96] !== exp_f.sat) begin
            fail_count++;
            if (mismatches < 10)
              $display({"ERROR: force mismatch: expected x=%h y=%h z=%h sat=%b, ",
                        "got x=%h y=%h z=%h sat=%b"},
                       exp_f.fx, exp_f.fy, exp_f.fz, exp_f.sat, out_tdata[31:0],
                       out_tdata[63:32], out_tdata[95:64], out_tdata[96]);
            mismatches++;
          end
        end
      end
    end
    pending = force_due.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Top of the testbench for soft_sphere_periodic_force: clock, reset, stimulus and verdict.
// Depends on ssp_pkg, the block itself and ssp_checker.
module tb;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [0:0]   in_tuser = '0;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [22:0]  cfg_data = '0;
  int           fail_count;
  int           pending;

  // Percent of beats preceded by a gap on the input, and percent of stalled cycles
  // on the result side.
  int           gap_pct = 0;
  int           stall_pct = 0;
  bit           written [4096];
  int           written_q [$];

  soft_sphere_periodic_force DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ssp_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The result side stalls at random with the current stall percentage.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard limit on the run; the slowest expected run is far below this.
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Each beat-sending task below is entered right after a rising edge and returns
  // right after the edge at which its beat was taken.
  task automatic send_beat(logic act, logic [103:0] data);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  task automatic load_entry(int idx, int x, int y, int z, int r);
    logic [23:0] px, py, pz;
    logic [19:0] pr;
    logic [11:0] pi;
    px = 24'(x); py = 24'(y); pz = 24'(z); pr = 20'(r); pi = 12'(idx);
    if (!written[pi]) begin
      written[pi] = 1'b1;
      written_q.push_back(int'(pi));
    end
    send_beat(ssp_pkg::ACT_LOAD, {pr, pz, py, px, pi});
  endtask

  task automatic query_entry(int idx);
    logic [11:0] pi;
    pi = 12'(idx);
    send_beat(ssp_pkg::ACT_QUERY, {92'd0, pi});
  endtask

  // Drops the input valid and waits until every query result has been taken,
  // then goes on waiting so that a trailing load has finished too.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(ssp_pkg::reg_idx_t r, int v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= 23'(v);
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_box();
    case ($urandom_range(5))
      0: return 0;
      1: return 23'h7FFFFF;
      default: return $urandom_range(20000, 200000);
    endcase
  endfunction

  // One randomized phase: a fresh setting, a scanned table filled with a cluster
  // of particles so that overlaps and image wrap-around are common, then a mix of
  // queries on written entries, reloads and loads of raw noise.
  task automatic random_phase(int n_items);
    int cnt, bx, by, bz, r;
    wait_idle();
    cnt = $urandom_range(1, 12);
    bx = pick_box(); by = pick_box(); bz = pick_box();
    write_reg(ssp_pkg::REG_BOX_X, bx);
    write_reg(ssp_pkg::REG_BOX_Y, by);
    write_reg(ssp_pkg::REG_BOX_Z, bz);
    write_reg(ssp_pkg::REG_GAIN, $urandom_range(0, 65535));
    write_reg(ssp_pkg::REG_COUNT, cnt);
    for (int j = 0; j < cnt; j++)
      load_entry(j, $urandom_range(0, 60000), $urandom_range(0, 60000),
                 $urandom_range(0, 60000), $urandom_range(0, 40000));
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      if (r < 60)
        query_entry(written_q[$urandom_range(written_q.size() - 1)]);
      else if (r < 85)
        load_entry($urandom_range(0, cnt + 3), $urandom_range(0, 60000),
                   $urandom_range(0, 60000), $urandom_range(0, 60000),
                   $urandom_range(0, 40000));
      else
        load_entry($urandom_range(0, 4095), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, a single particle overlapping only itself.
    load_entry(0, 1000, 2000, 3000, 500);
    query_entry(0);

    // Directed: field extremes, largest box on x, no box on z, full gain.
    wait_idle();
    write_reg(ssp_pkg::REG_BOX_X, 23'h7FFFFF);
    write_reg(ssp_pkg::REG_BOX_Y, 40960);
    write_reg(ssp_pkg::REG_BOX_Z, 0);
    write_reg(ssp_pkg::REG_GAIN, 65535);
    write_reg(ssp_pkg::REG_COUNT, 4);
    load_entry(0, -8388608, 8388607, 0, 1048575);
    load_entry(1, 8388607, -8388608, 1000, 0);
    load_entry(2, 0, 0, 0, 1048575);
    load_entry(3, 1 << 20, 5000, -5000, 20'h80000);
    load_entry(4095, 40000, 100, -100, 1048575);
    query_entry(0);
    query_entry(1);
    query_entry(2);
    query_entry(3);
    query_entry(4095);

    // Directed: particles hugging the faces of a 10.0 box so every image gate opens.
    wait_idle();
    write_reg(ssp_pkg::REG_BOX_X, 40960);
    write_reg(ssp_pkg::REG_BOX_Y, 40960);
    write_reg(ssp_pkg::REG_BOX_Z, 40960);
    write_reg(ssp_pkg::REG_GAIN, 6554);
    write_reg(ssp_pkg::REG_COUNT, 3);
    load_entry(0, 100, 100, 100, 4096);
    load_entry(1, 40860, 40860, 40860, 4096);
    load_entry(2, 20480, 40000, 300, 8192);
    query_entry(0);
    query_entry(1);
    query_entry(2);

    // Directed: zero gain, then an empty scan.
    wait_idle();
    write_reg(ssp_pkg::REG_GAIN, 0);
    query_entry(0);
    wait_idle();
    write_reg(ssp_pkg::REG_COUNT, 0);
    query_entry(1);

    // Random phases under each idling pattern, with stretches of none.
    random_phase(15);
    gap_pct = 60; stall_pct = 0;
    random_phase(15);
    gap_pct = 0; stall_pct = 60;
    random_phase(15);
    gap_pct = 16; stall_pct = 16;
    random_phase(15);

    // Saturation: a dense cluster around entry 0 with no box, so all 27 images of
    // every neighbor coincide and the x sum on entry 0 clips.
    wait_idle();
    gap_pct = 0; stall_pct = 0;
    write_reg(ssp_pkg::REG_BOX_X, 0);
    write_reg(ssp_pkg::REG_BOX_Y, 0);
    write_reg(ssp_pkg::REG_BOX_Z, 0);
    write_reg(ssp_pkg::REG_GAIN, 65535);
    write_reg(ssp_pkg::REG_COUNT, 41);
    load_entry(0, 0, 0, 0, 1048575);
    for (int j = 1; j < 41; j++)
      load_entry(j, $urandom_range(2010000, 2080000), $urandom_range(0, 1000),
                 $urandom_range(0, 1000), 1048575);
    query_entry(0);
    gap_pct = 16; stall_pct = 16;
    query_entry($urandom_range(1, 40));
    query_entry(4095);

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
